// ===== rtl/awgc_pkg.sv =====
// ----------------------------------------------------------------------------
// awgc_pkg: shared types and constants for the gesture classifier
// Sample index sizing, register index codes, gesture codes and the index
// marker type used by the swing trackers.
// ----------------------------------------------------------------------------
package awgc_pkg;

    // Longest window the index counter supports
    localparam int MAX_WINDOW = 128;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    // Width used to compare the position against the window length register
    localparam int CNT_W      = (LEN_W > 8) ? LEN_W : 8;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int SWING_W    = 15;
    localparam int JUMP_W     = 16;
    localparam int WLEN_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [SWING_W-1:0] SWING_RESET = 15'd2048;
    localparam logic [JUMP_W-1:0]  JUMP_RESET  = 16'hF4CD;   // -2867
    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 8'd80;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SWING_THRESHOLD = 2'd0,
        REG_JUMP_THRESHOLD  = 2'd1,
        REG_WINDOW_LENGTH   = 2'd2
    } cfg_reg_t;

    // Result codes
    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_JUMP  = 2'd1,
        GEST_Y     = 2'd2,
        GEST_X     = 2'd3
    } gesture_t;

    // Sample index with a valid flag
    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } idx_mark_t;

endpackage

// ===== rtl/awgc_swing_track.sv =====
// ----------------------------------------------------------------------------
// awgc_swing_track: swing detector for one axis
// Keeps the latest index beyond +T and beyond -T, and the latest index that
// was followed by a sample on the opposite side. The updated best index is
// also presented combinationally so the window end can use this sample.
// ----------------------------------------------------------------------------
module awgc_swing_track (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   advance,    // sample accepted
    input  logic                                   clear,      // last sample of window
    input  logic signed [awgc_pkg::SAMPLE_W-1:0]   sample,
    input  logic        [awgc_pkg::SWING_W-1:0]    threshold,
    input  logic        [awgc_pkg::IDX_W-1:0]      idx,
    output awgc_pkg::idx_mark_t                    best_next
);

    awgc_pkg::idx_mark_t pos_reg,  pos_next;
    awgc_pkg::idx_mark_t neg_reg,  neg_next;
    awgc_pkg::idx_mark_t best_reg;

    logic signed [awgc_pkg::SAMPLE_W:0] sample_ext;
    logic signed [awgc_pkg::SAMPLE_W:0] th_ext;
    logic                               above;
    logic                               below;

    // Strict compares against +T and -T in one extra bit
    assign sample_ext = {sample[awgc_pkg::SAMPLE_W-1], sample};
    assign th_ext     = $signed({2'b00, threshold});
    assign above      = sample_ext > th_ext;
    assign below      = sample_ext < -th_ext;

    // Marker update for this sample
    always_comb begin
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        best_next = best_reg;
        if (above) begin
            if (neg_reg.ok) begin
                best_next = neg_reg;
            end
            pos_next = '{ok: 1'b1, idx: idx};
        end else if (below) begin
            if (pos_reg.ok) begin
                best_next = pos_reg;
            end
            neg_next = '{ok: 1'b1, idx: idx};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            neg_reg  <= '0;
            best_reg <= '0;
        end else if (advance) begin
            if (clear) begin
                pos_reg  <= '0;
                neg_reg  <= '0;
                best_reg <= '0;
            end else begin
                pos_reg  <= pos_next;
                neg_reg  <= neg_next;
                best_reg <= best_next;
            end
        end
    end

endmodule

// ===== rtl/accel_window_gesture_classifier.sv =====
// ----------------------------------------------------------------------------
// accel_window_gesture_classifier: windowed swing / jump gesture classifier
// Takes one three-axis sample per transaction and emits one gesture code
// after the last sample of each window.
// ----------------------------------------------------------------------------
// Result: m_tvalid rises in the cycle after the window's last sample is
//   accepted.
// Throughput: one sample per cycle; the result register frees itself when
//   m_tready is high, so input stalls only while a result waits unread.
// Reset: aresetn synchronous active low; clears window state, result valid
//   and restores thresholds 2048 / -2867 and window length 80.
// ----------------------------------------------------------------------------
module accel_window_gesture_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input samples
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [47:0]                          s_tdata,   // accel_x, accel_y, accel_z
    // Results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // gesture, zero fill
    // Configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [awgc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [awgc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // Configuration registers
    logic [awgc_pkg::SWING_W-1:0]        swing_th_reg;
    logic signed [awgc_pkg::JUMP_W-1:0]  jump_th_reg;
    logic [awgc_pkg::WLEN_W-1:0]         win_len_reg;

    // Window state
    logic [awgc_pkg::IDX_W-1:0]          sample_idx_reg;
    awgc_pkg::idx_mark_t                 z_reg, z_next;
    awgc_pkg::idx_mark_t                 x_best_next, y_best_next;

    // Result register
    logic                                m_valid_reg;
    awgc_pkg::gesture_t                  gesture_reg, gesture_next;

    logic                                accept;
    logic                                window_end;
    logic [awgc_pkg::CNT_W-1:0]          eff_len;
    logic [awgc_pkg::CNT_W-1:0]          idx_plus1;

    logic signed [awgc_pkg::SAMPLE_W-1:0] accel_x;
    logic signed [awgc_pkg::SAMPLE_W-1:0] accel_y;
    logic signed [awgc_pkg::SAMPLE_W-1:0] accel_z;

    assign accel_x = s_tdata[15:0];
    assign accel_y = s_tdata[31:16];
    assign accel_z = s_tdata[47:32];

    // Take a sample unless a finished result is stuck in the output register
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Config write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swing_th_reg <= awgc_pkg::SWING_RESET;
            jump_th_reg  <= awgc_pkg::JUMP_RESET;
            win_len_reg  <= awgc_pkg::WLEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                awgc_pkg::REG_SWING_THRESHOLD: swing_th_reg <= cfg_wdata[awgc_pkg::SWING_W-1:0];
                awgc_pkg::REG_JUMP_THRESHOLD:  jump_th_reg  <= cfg_wdata[awgc_pkg::JUMP_W-1:0];
                awgc_pkg::REG_WINDOW_LENGTH:   win_len_reg  <= cfg_wdata[awgc_pkg::WLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective window length: zero counts as one, capped at the maximum
    always_comb begin
        eff_len = awgc_pkg::CNT_W'(win_len_reg);
        if (win_len_reg == '0) begin
            eff_len = awgc_pkg::CNT_W'(1);
        end else if (eff_len > awgc_pkg::CNT_W'(awgc_pkg::MAX_WINDOW)) begin
            eff_len = awgc_pkg::CNT_W'(awgc_pkg::MAX_WINDOW);
        end
    end

    assign idx_plus1  = awgc_pkg::CNT_W'(sample_idx_reg) + awgc_pkg::CNT_W'(1);
    assign window_end = !(idx_plus1 < eff_len);

    // Swing trackers for x and y
    awgc_swing_track u_x_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .clear     (window_end),
        .sample    (accel_x),
        .threshold (swing_th_reg),
        .idx       (sample_idx_reg),
        .best_next (x_best_next)
    );

    awgc_swing_track u_y_track (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (accept),
        .clear     (window_end),
        .sample    (accel_y),
        .threshold (swing_th_reg),
        .idx       (sample_idx_reg),
        .best_next (y_best_next)
    );

    // Jump detect
    always_comb begin
        z_next = z_reg;
        if (accel_z > jump_th_reg) begin
            z_next = '{ok: 1'b1, idx: sample_idx_reg};
        end
    end

    // Position counter and jump marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_idx_reg <= '0;
            z_reg          <= '0;
        end else if (accept) begin
            if (window_end) begin
                sample_idx_reg <= '0;
                z_reg          <= '0;
            end else begin
                sample_idx_reg <= idx_plus1[awgc_pkg::IDX_W-1:0];
                z_reg          <= z_next;
            end
        end
    end

    // Pick the latest firing index; on a tie z beats y beats x
    always_comb begin
        logic                       have;
        logic [awgc_pkg::IDX_W-1:0] best;
        have         = 1'b0;
        best         = '0;
        gesture_next = awgc_pkg::GEST_NONE;
        if (x_best_next.ok) begin
            have         = 1'b1;
            best         = x_best_next.idx;
            gesture_next = awgc_pkg::GEST_X;
        end
        if (y_best_next.ok && (!have || y_best_next.idx >= best)) begin
            have         = 1'b1;
            best         = y_best_next.idx;
            gesture_next = awgc_pkg::GEST_Y;
        end
        if (z_next.ok && (!have || z_next.idx >= best)) begin
            gesture_next = awgc_pkg::GEST_JUMP;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && window_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && window_end) begin
            gesture_reg <= gesture_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, gesture_reg};

`ifndef SYNTHESIS
    // Window end always produces a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && window_end |=> m_tvalid)
        else $error("window end did not raise m_tvalid");

    // Position restarts after a window end
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && window_end |=> sample_idx_reg == '0)
        else $error("sample index not cleared at window end");

    // A waiting result blocks new samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("sample accepted while result stalled");
`endif

endmodule
